[rtl/core/mksd_pkg.sv]
package mksd_pkg;

  // Register map: index of each configuration register (byte address is 8 * index).
  localparam logic [2:0] REG_DEBOUNCE_PERIOD  = 3'd0;
  localparam logic [2:0] REG_INTEGRATE_RATIO  = 3'd1;
  localparam logic [2:0] REG_DASH_THRESHOLD   = 3'd2;
  localparam logic [2:0] REG_TRANSITION_TABLE = 3'd3;
  localparam logic [2:0] REG_ACCEPT_STATE     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_PERIOD_RST  = 16'd1025;
  localparam logic [7:0]  INTEGRATE_RATIO_RST  = 8'd3;
  localparam logic [31:0] DASH_THRESHOLD_RST   = 32'd9999999;
  localparam logic [47:0] TRANSITION_TABLE_RST = 48'd278690379437121;
  localparam logic [2:0]  ACCEPT_STATE_RST     = 3'd7;

  // Event codes as they appear on the result word.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DOT  = 2'd1;
  localparam logic [1:0] EV_DASH = 2'd2;

  // Classification inputs handed from the timing front end to the pattern machine.
  typedef struct packed {
    logic capture_nonzero;
    logic short_press;
    logic release_full;
    logic long_release_full;
  } class_info_t;

endpackage

[rtl/core/mksd_timing.sv]
module mksd_timing #(
  parameter int TIMER_BITS = 32,
  parameter int LEVEL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 key,
  input  logic                 clear_capture,
  input  logic [15:0]          debounce_period,
  input  logic [7:0]           integrate_ratio,
  input  logic [31:0]          dash_threshold,
  output mksd_pkg::class_info_t info
);

  logic                  last_raw_level;
  logic [TIMER_BITS-1:0] press_timer;
  logic                  timer_running;
  logic [TIMER_BITS-1:0] captured_length;
  logic [15:0]           prescale_count;
  logic [LEVEL_BITS-1:0] release_level;
  logic [LEVEL_BITS-1:0] long_release_level;
  logic [7:0]            ratio_count;

  logic [TIMER_BITS-1:0] timer_inc;
  logic [TIMER_BITS-1:0] press_timer_next;
  logic                  timer_running_next;
  logic [TIMER_BITS-1:0] captured_length_next;
  logic [16:0]           prescale_inc;
  logic                  debounce_tick;
  logic [15:0]           prescale_count_next;
  logic [LEVEL_BITS-1:0] release_level_next;
  logic [8:0]            ratio_inc;
  logic                  ratio_tick;
  logic [7:0]            ratio_count_next;
  logic [LEVEL_BITS-1:0] long_release_level_next;

  // Press timer: saturating count while running, restarted on a press edge
  // and captured on a release edge.
  always_comb begin
    timer_inc = press_timer;
    if (timer_running && (press_timer != '1)) begin
      timer_inc = press_timer + 1'b1;
    end
    press_timer_next     = timer_inc;
    timer_running_next   = timer_running;
    captured_length_next = captured_length;
    if (key && !last_raw_level) begin
      press_timer_next     = '0;
      captured_length_next = '0;
      timer_running_next   = 1'b1;
    end else if (!key && last_raw_level) begin
      captured_length_next = timer_inc;
      timer_running_next   = 1'b0;
      press_timer_next     = '0;
    end
  end

  // Debounce prescaler and the first integrator.
  always_comb begin
    prescale_inc        = {1'b0, prescale_count} + 17'd1;
    debounce_tick       = (prescale_inc >= {1'b0, debounce_period});
    prescale_count_next = debounce_tick ? '0 : prescale_inc[15:0];
    release_level_next  = release_level;
    if (debounce_tick) begin
      if (key) begin
        if (release_level != '0) begin
          release_level_next = release_level - 1'b1;
        end
      end else begin
        if (release_level != '1) begin
          release_level_next = release_level + 1'b1;
        end
      end
    end
  end

  // Second integrator, updated every integrate_ratio debounce ticks.
  always_comb begin
    ratio_inc               = {1'b0, ratio_count} + 9'd1;
    ratio_tick              = (ratio_inc >= {1'b0, integrate_ratio});
    ratio_count_next        = ratio_count;
    long_release_level_next = long_release_level;
    if (debounce_tick) begin
      ratio_count_next = ratio_tick ? '0 : ratio_inc[7:0];
      if (ratio_tick) begin
        if (release_level_next == '1) begin
          if (long_release_level != '1) begin
            long_release_level_next = long_release_level + 1'b1;
          end
        end else if (release_level_next == '0) begin
          long_release_level_next = '0;
        end
      end
    end
  end

  // Classification inputs are taken from the values after this tick's updates.
  always_comb begin
    info.capture_nonzero   = (captured_length_next != '0);
    info.short_press       = (32'(captured_length_next) < dash_threshold);
    info.release_full      = (release_level_next == '1);
    info.long_release_full = (long_release_level_next == '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_level     <= 1'b0;
      press_timer        <= '0;
      timer_running      <= 1'b0;
      captured_length    <= '0;
      prescale_count     <= '0;
      release_level      <= '0;
      long_release_level <= '0;
      ratio_count        <= '0;
    end else if (step) begin
      last_raw_level     <= key;
      press_timer        <= press_timer_next;
      timer_running      <= timer_running_next;
      captured_length    <= clear_capture ? '0 : captured_length_next;
      prescale_count     <= prescale_count_next;
      release_level      <= release_level_next;
      long_release_level <= long_release_level_next;
      ratio_count        <= ratio_count_next;
    end
  end

  // A stopped timer always reads zero.
  a_stopped_timer_zero: assert property (@(posedge clk) disable iff (rst)
    !timer_running |-> (press_timer == '0))
    else $error("press timer nonzero while stopped");

  // A pending captured length only exists while no press is being timed.
  a_capture_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    (captured_length != '0) |-> !timer_running)
    else $error("captured length held while the timer runs");

endmodule

[rtl/core/mksd_fsm.sv]
module mksd_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  mksd_pkg::class_info_t info,
  input  logic [47:0]           transition_table,
  input  logic [2:0]            accept_state,
  output logic                  clear_capture,
  output logic [2:0]            state_next,
  output logic [1:0]            event_next,
  output logic                  match_next
);

  logic       match_flag;
  logic [2:0] machine_state;
  logic [2:0] table_entry [16];

  // Unpack the transition table into its sixteen next-state entries.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      table_entry[i] = transition_table[3*i +: 3];
    end
  end

  // Classify the pending press and step the machine unless already matched.
  always_comb begin
    event_next = mksd_pkg::EV_NONE;
    if (!match_flag && info.capture_nonzero) begin
      if (info.release_full && info.short_press) begin
        event_next = mksd_pkg::EV_DOT;
      end else if (info.long_release_full && !info.short_press) begin
        event_next = mksd_pkg::EV_DASH;
      end
    end
    clear_capture = (event_next != mksd_pkg::EV_NONE);
    state_next    = machine_state;
    if (clear_capture) begin
      state_next = table_entry[{machine_state, (event_next == mksd_pkg::EV_DASH)}];
    end
    match_next = match_flag || (state_next == accept_state);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_state <= '0;
      match_flag    <= 1'b0;
    end else if (step) begin
      machine_state <= state_next;
      match_flag    <= match_next;
    end
  end

  // Once matched the machine is frozen.
  a_frozen_after_match: assert property (@(posedge clk) disable iff (rst)
    match_flag |=> $stable(machine_state))
    else $error("machine state moved after a match");

  // No event is classified once matched.
  a_no_event_after_match: assert property (@(posedge clk) disable iff (rst)
    match_flag |-> (event_next == mksd_pkg::EV_NONE))
    else $error("event classified after a match");

endmodule

[rtl/core/morse_key_sequence_detector.sv]
// Pipeline: an accepted key word is held in the input register, then in the result register
// (one input register, one result register).
// Throughput: one key word per cycle; the result register is backed by the input stage,
// so the block keeps accepting while the result side is ready.
// Reset (rst, synchronous): pipeline empty, timer and integrators cleared, machine in
// state 0 and unmatched, configuration registers back to their default values.
module morse_key_sequence_detector #(
  parameter int TIMER_BITS = 32,
  parameter int LEVEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        key_valid,
  output logic        key_ready,
  input  logic        key_pressed,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  sequence_state,
  output logic [1:0]  event_code,
  output logic        matched
);

  logic [15:0] debounce_period;
  logic [7:0]  integrate_ratio;
  logic [31:0] dash_threshold;
  logic [47:0] transition_table;
  logic [2:0]  accept_state;

  logic        s1_valid;
  logic        s1_key;
  logic        advance;
  logic        clear_capture;
  logic [2:0]  state_next;
  logic [1:0]  event_next;
  logic        match_next;
  logic [2:0]  reg_index;
  mksd_pkg::class_info_t info;

  assign pready    = 1'b1;
  assign reg_index = paddr[5:3];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_period  <= mksd_pkg::DEBOUNCE_PERIOD_RST;
      integrate_ratio  <= mksd_pkg::INTEGRATE_RATIO_RST;
      dash_threshold   <= mksd_pkg::DASH_THRESHOLD_RST;
      transition_table <= mksd_pkg::TRANSITION_TABLE_RST;
      accept_state     <= mksd_pkg::ACCEPT_STATE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        mksd_pkg::REG_DEBOUNCE_PERIOD:  debounce_period  <= pwdata[15:0];
        mksd_pkg::REG_INTEGRATE_RATIO:  integrate_ratio  <= pwdata[7:0];
        mksd_pkg::REG_DASH_THRESHOLD:   dash_threshold   <= pwdata[31:0];
        mksd_pkg::REG_TRANSITION_TABLE: transition_table <= pwdata[47:0];
        mksd_pkg::REG_ACCEPT_STATE:     accept_state     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    unique case (reg_index)
      mksd_pkg::REG_DEBOUNCE_PERIOD:  prdata = 64'(debounce_period);
      mksd_pkg::REG_INTEGRATE_RATIO:  prdata = 64'(integrate_ratio);
      mksd_pkg::REG_DASH_THRESHOLD:   prdata = 64'(dash_threshold);
      mksd_pkg::REG_TRANSITION_TABLE: prdata = 64'(transition_table);
      mksd_pkg::REG_ACCEPT_STATE:     prdata = 64'(accept_state);
      default:                        prdata = '0;
    endcase
  end

  // The input stage moves into the result register whenever that register is free
  // or being emptied in the same cycle.
  assign advance   = s1_valid && (!result_valid || result_ready);
  assign key_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_ready) begin
      s1_valid <= key_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_valid && key_ready) begin
      s1_key <= key_pressed;
    end
  end

  mksd_timing #(
    .TIMER_BITS (TIMER_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_timing (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .key             (s1_key),
    .clear_capture   (clear_capture),
    .debounce_period (debounce_period),
    .integrate_ratio (integrate_ratio),
    .dash_threshold  (dash_threshold),
    .info            (info)
  );

  mksd_fsm u_fsm (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .info             (info),
    .transition_table (transition_table),
    .accept_state     (accept_state),
    .clear_capture    (clear_capture),
    .state_next       (state_next),
    .event_next       (event_next),
    .match_next       (match_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sequence_state <= state_next;
      event_code     <= event_next;
      matched        <= match_next;
    end
  end

  // An accepted word always occupies the input stage on the next cycle.
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (key_valid && key_ready) |=> s1_valid)
    else $error("accepted key word lost from the input stage");

  // Every word leaving the input stage lands in the result register.
  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("result word lost between stages");

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 8;

  // One result word as the block should present it.
  typedef struct packed {
    logic [2:0] sequence_state;
    logic [1:0] event_code;
    logic       matched;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        key_valid = 1'b0;
  logic        key_ready;
  logic        key_pressed = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  sequence_state;
  logic [1:0]  event_code;
  logic        matched;

  // Shadow copy of the configuration registers.
  logic [15:0] cfg_debounce_period  = mksd_pkg::DEBOUNCE_PERIOD_RST;
  logic [7:0]  cfg_integrate_ratio  = mksd_pkg::INTEGRATE_RATIO_RST;
  logic [31:0] cfg_dash_threshold   = mksd_pkg::DASH_THRESHOLD_RST;
  logic [47:0] cfg_transition_table = mksd_pkg::TRANSITION_TABLE_RST;
  logic [2:0]  cfg_accept_state     = mksd_pkg::ACCEPT_STATE_RST;

  // Predicted internal state of the detector.
  logic        prev_key_level  = 1'b0;
  logic [31:0] press_ticks     = '0;
  logic        timer_on        = 1'b0;
  logic [31:0] held_length     = '0;
  logic [16:0] prescale_ticks  = '0;
  logic [7:0]  short_level     = '0;
  logic [7:0]  long_level      = '0;
  logic [8:0]  update_count    = '0;
  logic [2:0]  pattern_state   = '0;
  logic        pattern_matched = 1'b0;

  tick_result_t expected_ticks[$];
  int error_count       = 0;
  int stall_cycles      = 0;
  int words_sent        = 0;
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_off_left     = 0;
  bit hold_off_request  = 1'b0;

  morse_key_sequence_detector u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .key_valid      (key_valid),
    .key_ready      (key_ready),
    .key_pressed    (key_pressed),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .sequence_state (sequence_state),
    .event_code     (event_code),
    .matched        (matched)
  );

  always #6 clk = ~clk;

  // Advance the predicted detector by one key tick and return its result word.
  function automatic tick_result_t predict_key_tick(input logic key);
    tick_result_t res;
    logic [1:0]   ev;
    logic [3:0]   slot;
    ev = mksd_pkg::EV_NONE;

    // Press timer and edge capture.
    if (timer_on && press_ticks != 32'hFFFF_FFFF) begin
      press_ticks = press_ticks + 32'd1;
    end
    if (key && !prev_key_level) begin
      press_ticks = '0;
      held_length = '0;
      timer_on = 1'b1;
    end else if (!key && prev_key_level) begin
      held_length = press_ticks;
      timer_on = 1'b0;
      press_ticks = '0;
    end
    prev_key_level = key;

    // Two-stage debounce integrators.
    prescale_ticks = prescale_ticks + 17'd1;
    if (prescale_ticks >= {1'b0, cfg_debounce_period}) begin
      prescale_ticks = '0;
      if (key) begin
        if (short_level != 8'h00) short_level = short_level - 8'd1;
      end else begin
        if (short_level != 8'hFF) short_level = short_level + 8'd1;
      end
      update_count = update_count + 9'd1;
      if (update_count >= {1'b0, cfg_integrate_ratio}) begin
        update_count = '0;
        if (short_level == 8'hFF) begin
          if (long_level != 8'hFF) long_level = long_level + 8'd1;
        end else if (short_level == 8'h00) begin
          long_level = '0;
        end
      end
    end

    // Classification and the pattern machine, frozen once matched.
    if (!pattern_matched) begin
      if (held_length != 32'd0) begin
        if (short_level == 8'hFF && held_length < cfg_dash_threshold) begin
          ev = mksd_pkg::EV_DOT;
        end else if (long_level == 8'hFF && held_length >= cfg_dash_threshold) begin
          ev = mksd_pkg::EV_DASH;
        end
        if (ev != mksd_pkg::EV_NONE) begin
          slot = {pattern_state, ev == mksd_pkg::EV_DASH};
          pattern_state = cfg_transition_table[3 * slot +: 3];
          held_length = '0;
        end
      end
      if (pattern_state == cfg_accept_state) pattern_matched = 1'b1;
    end

    res.sequence_state = pattern_state;
    res.event_code = ev;
    res.matched = pattern_matched;
    return res;
  endfunction

  // A random table whose next states never lead into the given state.
  function automatic logic [47:0] random_table(input logic [2:0] avoid);
    logic [47:0] tbl;
    logic [2:0]  entry;
    for (int i = 0; i < 16; i++) begin
      entry = 3'($urandom_range(6));
      if (entry >= avoid) entry = entry + 3'd1;
      tbl[3 * i +: 3] = entry;
    end
    return tbl;
  endfunction

  // An accept state away from the present one, leaning towards the extremes.
  function automatic logic [2:0] pick_accept();
    logic [2:0] acc;
    case ($urandom_range(2))
      0: begin
        acc = 3'd0;
      end
      1: begin
        acc = 3'd7;
      end
      default: begin
        acc = 3'($urandom_range(7));
      end
    endcase
    if (acc == pattern_state) acc = acc + 3'd1;
    return acc;
  endfunction

  // Offer one key word and record its predicted result once it is taken.
  task automatic send_key_word(input logic level);
    if ($urandom_range(99) < sender_idle_pct) begin
      key_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    key_valid = 1'b1;
    key_pressed = level;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    expected_ticks.push_back(predict_key_tick(level));
    words_sent++;
    @(negedge clk);
    key_valid = 1'b0;
  endtask

  // Either a press and release long enough to settle, or a burst of glitches.
  task automatic send_key_pattern();
    int press_len;
    int release_len;
    int scale;
    scale = (cfg_debounce_period == 16'd0) ? 1 :
            (cfg_debounce_period > 16'd4) ? 4 : int'(cfg_debounce_period);
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(6, 1)) send_key_word(1'($urandom_range(1)));
    end else begin
      press_len = $urandom_range(16, 1);
      release_len = press_len * scale + $urandom_range(12);
      if ($urandom_range(99) < 10) release_len += $urandom_range(80, 40);
      repeat (press_len) send_key_word(1'b1);
      repeat (release_len) send_key_word(1'b0);
    end
  endtask

  // Let every outstanding word come back, then a few more cycles.
  task automatic wait_for_idle();
    while (expected_ticks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write followed by a read-back check.
  task automatic write_register(input logic [2:0] reg_index, input logic [63:0] value);
    logic [63:0] width_mask;
    case (reg_index)
      mksd_pkg::REG_DEBOUNCE_PERIOD: begin
        width_mask = 64'hFFFF;
        cfg_debounce_period = value[15:0];
      end
      mksd_pkg::REG_INTEGRATE_RATIO: begin
        width_mask = 64'hFF;
        cfg_integrate_ratio = value[7:0];
      end
      mksd_pkg::REG_DASH_THRESHOLD: begin
        width_mask = 64'hFFFF_FFFF;
        cfg_dash_threshold = value[31:0];
      end
      mksd_pkg::REG_TRANSITION_TABLE: begin
        width_mask = 64'hFFFF_FFFF_FFFF;
        cfg_transition_table = value[47:0];
      end
      mksd_pkg::REG_ACCEPT_STATE: begin
        width_mask = 64'h7;
        cfg_accept_state = value[2:0];
      end
      default: begin
        width_mask = '0;
      end
    endcase
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_index, 3'b000};
    pwdata = value & width_mask;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if ((prdata & width_mask) !== (value & width_mask)) begin
      error_count++;
      $display("%0t: register %0d read back expected 0x%0h, got 0x%0h", $time, reg_index,
               value & width_mask, prdata & width_mask);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(input logic [15:0] period, input logic [7:0] ratio,
                           input logic [31:0] threshold, input logic [47:0] tbl,
                           input logic [2:0] accept);
    wait_for_idle();
    write_register(mksd_pkg::REG_DEBOUNCE_PERIOD, 64'(period));
    write_register(mksd_pkg::REG_INTEGRATE_RATIO, 64'(ratio));
    write_register(mksd_pkg::REG_DASH_THRESHOLD, 64'(threshold));
    write_register(mksd_pkg::REG_TRANSITION_TABLE, 64'(tbl));
    write_register(mksd_pkg::REG_ACCEPT_STATE, 64'(accept));
  endtask

  // Register extremes with presses and releases of one and two ticks.
  task automatic test_register_extremes();
    configure(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 48'h0, 3'd7);
    send_key_word(1'b1);
    send_key_word(1'b0);
    send_key_word(1'b1);
    send_key_word(1'b1);
    send_key_word(1'b0);
    send_key_word(1'b0);
    send_key_word(1'b1);
    send_key_word(1'b0);
    send_key_word(1'b0);
    send_key_word(1'b1);
  endtask

  // Zero period, zero ratio and zero threshold together.
  task automatic test_zero_settings();
    logic [2:0]  acc;
    logic [11:0] levels;
    acc = pick_accept();
    levels = 12'b1100_1011_1000;
    configure(16'd0, 8'd0, 32'd0, random_table(acc), acc);
    for (int i = 11; i >= 0; i--) send_key_word(levels[i]);
  endtask

  // Long release so that both integrators reach full scale.
  task automatic test_debounce_warm_up();
    logic [2:0] acc;
    acc = pick_accept();
    configure(16'd1, 8'd0, 32'd8, random_table(acc), acc);
    repeat (520) send_key_word(1'b0);
  endtask

  task automatic test_random_sequences(input int phases, input int words_per_phase);
    logic [15:0] period;
    logic [7:0]  ratio;
    logic [31:0] threshold;
    logic [2:0]  acc;
    int          r;
    int          target;
    for (int p = 0; p < phases; p++) begin
      r = $urandom_range(99);
      if (r < 70) period = 16'($urandom_range(2, 1));
      else if (r < 80) period = 16'd0;
      else if (r < 90) period = 16'($urandom_range(6, 3));
      else period = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
      r = $urandom_range(99);
      if (r < 60) ratio = 8'($urandom_range(2));
      else if (r < 90) ratio = 8'($urandom_range(10, 3));
      else ratio = 8'hFF;
      r = $urandom_range(99);
      if (r < 40) threshold = 32'($urandom_range(8, 1));
      else if (r < 60) threshold = 32'($urandom_range(16, 9));
      else if (r < 70) threshold = 32'd0;
      else if (r < 80) threshold = 32'hFFFF_FFFF;
      else threshold = $urandom;
      acc = pick_accept();
      configure(period, ratio, threshold, random_table(acc), acc);
      target = words_sent + words_per_phase;
      while (words_sent < target) send_key_pattern();
    end
  endtask

  // Saturated table, with the receiver holding off long enough to back up the input.
  task automatic test_input_stall();
    int target;
    configure(16'd1, 8'd0, 32'd8, 48'hFFFF_FFFF_FFFF, (pattern_state == 3'd0) ? 3'd1 : 3'd0);
    hold_off_request = 1'b1;
    target = words_sent + 60;
    while (words_sent < target) send_key_pattern();
  endtask

  // A press long enough to empty the first stage and clear the second.
  task automatic test_level_drain();
    logic [2:0] acc;
    acc = pick_accept();
    configure(16'd1, 8'd0, 32'd8, random_table(acc), acc);
    repeat (270) send_key_word(1'b1);
    repeat (300) send_key_word(1'b0);
  endtask

  // Accept state set to the present state: matched from the next tick, then frozen.
  task automatic test_match_and_freeze();
    int target;
    wait_for_idle();
    write_register(mksd_pkg::REG_ACCEPT_STATE, 64'(pattern_state));
    target = words_sent + 60;
    while (words_sent < target) send_key_pattern();
  endtask

  // Receiver: random back-pressure, or a long counted hold-off on request.
  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      result_ready = 1'b0;
      hold_off_left--;
    end else if (hold_off_request) begin
      hold_off_request = 1'b0;
      hold_off_left = HOLD_OFF_CYCLES;
      result_ready = 1'b0;
    end else begin
      result_ready = ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Compare every result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_ticks.size() == 0) begin
        error_count++;
        $display("%0t: result word with none expected: state %0d event %0d matched %0d",
                 $time, sequence_state, event_code, matched);
      end else begin
        want = expected_ticks.pop_front();
        if (sequence_state !== want.sequence_state) begin
          error_count++;
          $display("%0t: sequence_state expected %0d, got %0d", $time,
                   want.sequence_state, sequence_state);
        end
        if (event_code !== want.event_code) begin
          error_count++;
          $display("%0t: event_code expected %0d, got %0d", $time,
                   want.event_code, event_code);
        end
        if (matched !== want.matched) begin
          error_count++;
          $display("%0t: matched expected %0d, got %0d", $time, want.matched, matched);
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((key_valid && key_ready) || (result_valid && result_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("morse_key_sequence_detector regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    sender_idle_pct = 15;
    receiver_idle_pct = 53;
    test_register_extremes();
    test_zero_settings();
    test_debounce_warm_up();
    test_random_sequences(3, 15);

    sender_idle_pct = 53;
    receiver_idle_pct = 15;
    test_random_sequences(3, 15);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_input_stall();
    test_random_sequences(3, 15);
    test_level_drain();
    test_match_and_freeze();

    // Drain the last words and give the pipeline time to show any stray result.
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("morse_key_sequence_detector regression: pass");
    end else begin
      $display("morse_key_sequence_detector regression: fail");
    end
    $finish;
  end

endmodule
